[src/session_slot_allocator_oldest_evict_assert.svh]
// Assertion macros shared by the session slot allocator checkers.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SESSION_SLOT_ALLOCATOR_OLDEST_EVICT_ASSERT_SVH
`define SESSION_SLOT_ALLOCATOR_OLDEST_EVICT_ASSERT_SVH

// Checks a property at every rising clock edge outside of reset.
`define SSA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("session slot allocator check failed");

// Checks that a condition never holds outside of reset.
`define SSA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("session slot allocator forbidden condition seen");

`endif

[src/ssa_pkg.sv]
// Package for the session slot allocator: request and result types,
// controller states, command and status structs. No dependencies.
`default_nettype none

package ssa_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam logic [15:0] FLAP_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_NEW    = 2'd1,
        REQ_LOST   = 2'd2
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic        link_up;
        logic [1:0]  slot_index;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [1:0]  given_slot;
        logic        evicted;
        logic [3:0]  active_mask;
        logic [15:0] flap_total;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EVICT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic scan_init;
        logic scan_step;
        logic evict;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_scan;
        logic multi_slot;
        logic scan_last;
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

[src/ssa_datapath.sv]
// Datapath of the session slot allocator: slot table, link state, flap
// counter, oldest-stamp scan and result register. Depends on ssa_pkg.
`default_nettype none

module ssa_datapath
    import ssa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_item   i_in_item,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output t_out_item       o_out_item
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    t_in_item           r_req;
    logic [SLOT_COUNT-1:0] r_busy;
    logic [31:0]        r_stamp [SLOT_COUNT];
    logic               r_link_up;
    logic [15:0]        r_flap;
    logic [IW-1:0]      r_ptr;
    logic [IW-1:0]      r_best;
    logic [31:0]        r_best_stamp;
    logic               r_granted;
    logic [1:0]         r_given;
    logic               r_evicted;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [IW-1:0]      free_idx;
    logic               any_free;
    logic [3:0]         mask;

    always_comb begin
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_idx = IW'(i);
            end
        end
        any_free = ~&r_busy;
    end

    always_comb begin
        mask = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < SLOT_COUNT) begin
                mask[i] = r_busy[i];
            end
        end
    end

    always_comb begin
        o_status.need_scan  = (r_req.req_type == REQ_NEW) && r_link_up && !any_free;
        o_status.multi_slot = (SLOT_COUNT > 1);
        o_status.scan_last  = (r_ptr == IW'(SLOT_COUNT - 1));
        o_status.out_busy   = r_out_valid && i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_item;
        end
        if (i_cmd.scan_init) begin
            r_best       <= '0;
            r_best_stamp <= r_stamp[0];
            r_ptr        <= IW'(1);
        end else if (i_cmd.scan_step) begin
            if (r_stamp[r_ptr] < r_best_stamp) begin
                r_best       <= r_ptr;
                r_best_stamp <= r_stamp[r_ptr];
            end
            r_ptr <= r_ptr + IW'(1);
        end
        if (i_cmd.load_out) begin
            r_out.granted     <= r_granted;
            r_out.given_slot  <= r_given;
            r_out.evicted     <= r_evicted;
            r_out.active_mask <= mask;
            r_out.flap_total  <= r_flap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_link_up <= 1'b0;
            r_flap    <= '0;
            r_granted <= 1'b0;
            r_given   <= '0;
            r_evicted <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_stamp[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_granted <= 1'b0;
            r_given   <= '0;
            r_evicted <= 1'b0;
            unique case (r_req.req_type)
                REQ_SAMPLE: begin
                    if (r_link_up && !r_req.link_up && (r_flap != FLAP_MAX)) begin
                        r_flap <= r_flap + 16'd1;
                    end
                    r_link_up <= r_req.link_up;
                end
                REQ_NEW: begin
                    if (r_link_up && any_free) begin
                        r_busy[free_idx]  <= 1'b1;
                        r_stamp[free_idx] <= r_req.now_ms;
                        r_granted         <= 1'b1;
                        r_given           <= 2'(free_idx);
                    end
                end
                REQ_LOST: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (int'(r_req.slot_index) == i) begin
                            r_busy[i] <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.evict) begin
            r_stamp[r_best] <= r_req.now_ms;
            r_granted       <= 1'b1;
            r_given         <= 2'(r_best);
            r_evicted       <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

[src/ssa_controller.sv]
// Controller of the session slot allocator: sequences request capture,
// execution, the oldest-stamp scan and the result hand-off. Depends on ssa_pkg.
`default_nettype none

module ssa_controller
    import ssa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.need_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = i_status.multi_slot ? ST_SCAN : ST_EVICT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_EVICT;
                end
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/session_slot_allocator_oldest_evict.sv]
// A connection slot allocator with oldest-first eviction. Each request takes
// one result, and a new request waits until the last result is loaded. Link
// samples, lost connections and new connections with a free slot go through
// capture, execution and completion; one that must evict also scans the slot
// timestamps one slot per cycle to find the oldest. A result waits in an
// output register, so a stalled consumer holds back only the completion step.
// Top level: joins ssa_controller and ssa_datapath; depends on ssa_pkg.
`default_nettype none

module session_slot_allocator_oldest_evict
    import ssa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ssa_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ssa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

[src/ssa_checker.sv]
// Port-level checker for the session slot allocator and its bind statement.
// Depends on ssa_pkg and session_slot_allocator_oldest_evict_assert.svh.
`default_nettype none
`include "session_slot_allocator_oldest_evict_assert.svh"

module ssa_checker
    import ssa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    `SSA_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid)
    `SSA_ASSERT(a_one_at_a_time, i_in_valid && !o_in_stall |=> o_in_stall)
    `SSA_ASSERT(a_reset_clears_out, !$past(i_rst_n) |-> !o_out_valid)
    `SSA_ASSERT_NEVER(a_no_grant_clean,
        o_out_valid && !o_out_item.granted
            && (o_out_item.evicted || (o_out_item.given_slot != 2'd0)))
    `SSA_ASSERT(a_grant_marks_slot,
        (SLOT_COUNT <= 4) && o_out_valid && o_out_item.granted
            |-> o_out_item.active_mask[o_out_item.given_slot])

endmodule

bind session_slot_allocator_oldest_evict ssa_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_ssa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for session_slot_allocator_oldest_evict: slot grants,
// oldest-first eviction, lost connections and the link flap count.
// Needs ssa_pkg and the RTL only; a predictor or directed row checks each result.
`timescale 1ns / 1ps

module tb
    import ssa_pkg::*;
();

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int RANDOM_PER_PHASE = 425;
    localparam int TAIL_ITEMS = 40;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam t_req_type REQ_SPARE = t_req_type'(2'd3);

    typedef struct {
        t_in_item  req;
        logic      typed;
        t_out_item want;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    // Predictor state.
    logic        slot_taken [SLOTS];
    logic [31:0] slot_time [SLOTS];
    logic        link_seen_up;
    logic [15:0] flap_seen;

    t_out_item   awaited_results [$];
    t_row        directed_rows [$];
    t_out_item   oldest;
    int          send_idle_pct;
    int          stall_pct;
    int          error_count;
    int          request_count;
    int          grant_count;
    int          evict_count;
    longint      cycle_count;

    session_slot_allocator_oldest_evict uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_out_item predict_outcome(input t_in_item req);
        t_out_item res;
        int        pick;
        logic      found;
        res = '0;
        pick = 0;
        found = 1'b0;
        case (req.req_type)
            REQ_SAMPLE: begin
                if (link_seen_up && !req.link_up && flap_seen != FLAP_MAX) begin
                    flap_seen = flap_seen + 16'd1;
                end
                link_seen_up = req.link_up;
            end
            REQ_NEW: begin
                if (link_seen_up) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && !slot_taken[i]) begin
                            found = 1'b1;
                            pick = i;
                        end
                    end
                    if (!found) begin
                        for (int i = 1; i < SLOTS; i++) begin
                            if (slot_time[i] < slot_time[pick]) begin
                                pick = i;
                            end
                        end
                    end
                    slot_taken[pick] = 1'b1;
                    slot_time[pick] = req.now_ms;
                    res.granted = 1'b1;
                    res.given_slot = pick[1:0];
                    res.evicted = !found;
                end
            end
            REQ_LOST: begin
                slot_taken[req.slot_index] = 1'b0;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < SLOTS; i++) begin
            res.active_mask[i] = slot_taken[i];
        end
        res.flap_total = flap_seen;
        return res;
    endfunction

    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 9);
        r.req_type = (pick < 25) ? REQ_SAMPLE :
                     (pick < 65) ? REQ_NEW :
                     (pick < 93) ? REQ_LOST : REQ_SPARE;
        r.link_up = (r.req_type == REQ_SAMPLE) ? ($urandom_range(0, 3) != 0)
                                               : 1'($urandom_range(0, 1));
        r.slot_index = 2'($urandom_range(0, 3));
        if (span < 5) begin
            r.now_ms = $urandom();
        end else if (span < 8) begin
            r.now_ms = $urandom_range(0, 7);
        end else begin
            r.now_ms = 32'hFFFF_FFF8 | $urandom_range(0, 7);
        end
        return r;
    endfunction

    // Starts and ends at a falling edge; valid stays high into the next request.
    task automatic issue(input t_in_item req, input logic typed, input t_out_item want);
        t_out_item got;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        got = predict_outcome(req);
        awaited_results.push_back(typed ? want : got);
        request_count++;
        if (got.granted) begin
            grant_count++;
        end
        if (got.evicted) begin
            evict_count++;
        end
        @(negedge i_clk);
    endtask

    task automatic add_row(input t_req_type kind, input logic up, input logic [1:0] idx,
                           input logic [31:0] stamp, input logic typed,
                           input t_out_item want);
        t_row row;
        row.req.req_type = kind;
        row.req.link_up = up;
        row.req.slot_index = idx;
        row.req.now_ms = stamp;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected result %h at cycle %0d", o_out_item, cycle_count);
                end
            end else begin
                oldest = awaited_results.pop_front();
                if (o_out_item.granted !== oldest.granted
                        || o_out_item.given_slot !== oldest.given_slot
                        || o_out_item.evicted !== oldest.evicted
                        || o_out_item.active_mask !== oldest.active_mask
                        || o_out_item.flap_total !== oldest.flap_total) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch cycle %0d granted %b/%b slot %0d/%0d",
                                 cycle_count, oldest.granted, o_out_item.granted,
                                 oldest.given_slot, o_out_item.given_slot);
                        $display("  evicted %b/%b mask %b/%b flaps %0d/%0d (expected/actual)",
                                 oldest.evicted, o_out_item.evicted,
                                 oldest.active_mask, o_out_item.active_mask,
                                 oldest.flap_total, o_out_item.flap_total);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", awaited_results.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        request_count = 0;
        grant_count = 0;
        evict_count = 0;
        cycle_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_taken[i] = 1'b0;
            slot_time[i] = '0;
        end
        link_seen_up = 1'b0;
        flap_seen = '0;

        // Link down after reset, then fill all four slots and evict three times.
        add_row(REQ_SAMPLE, 1'b0, 2'd0, 32'h0000_0000, 1'b1, {1'b0, 2'd0, 1'b0, 4'b0000, 16'd0});
        add_row(REQ_NEW,    1'b0, 2'd0, 32'h0000_0000, 1'b1, {1'b0, 2'd0, 1'b0, 4'b0000, 16'd0});
        add_row(REQ_LOST,   1'b0, 2'd3, 32'hFFFF_FFFF, 1'b1, {1'b0, 2'd0, 1'b0, 4'b0000, 16'd0});
        add_row(REQ_SPARE,  1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1, {1'b0, 2'd0, 1'b0, 4'b0000, 16'd0});
        add_row(REQ_SAMPLE, 1'b1, 2'd2, 32'h0000_0000, 1'b1, {1'b0, 2'd0, 1'b0, 4'b0000, 16'd0});
        add_row(REQ_NEW,    1'b0, 2'd1, 32'hFFFF_FFFF, 1'b1, {1'b1, 2'd0, 1'b0, 4'b0001, 16'd0});
        add_row(REQ_NEW,    1'b1, 2'd2, 32'h0000_0000, 1'b1, {1'b1, 2'd1, 1'b0, 4'b0011, 16'd0});
        add_row(REQ_NEW,    1'b0, 2'd3, 32'h0000_0005, 1'b1, {1'b1, 2'd2, 1'b0, 4'b0111, 16'd0});
        add_row(REQ_NEW,    1'b1, 2'd0, 32'h0000_0005, 1'b1, {1'b1, 2'd3, 1'b0, 4'b1111, 16'd0});
        add_row(REQ_NEW,    1'b0, 2'd0, 32'h0000_0007, 1'b1, {1'b1, 2'd1, 1'b1, 4'b1111, 16'd0});
        add_row(REQ_NEW,    1'b1, 2'd1, 32'h0000_0009, 1'b0, '0);
        add_row(REQ_NEW,    1'b0, 2'd2, 32'h0000_0009, 1'b0, '0);
        add_row(REQ_LOST,   1'b1, 2'd0, 32'h1234_5678, 1'b0, '0);
        add_row(REQ_NEW,    1'b1, 2'd3, 32'h8000_0000, 1'b0, '0);
        add_row(REQ_SAMPLE, 1'b0, 2'd1, 32'h0000_0001, 1'b1, {1'b0, 2'd0, 1'b0, 4'b1111, 16'd1});
        add_row(REQ_NEW,    1'b1, 2'd0, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(REQ_LOST,   1'b0, 2'd2, 32'h0000_0000, 1'b0, '0);
        add_row(REQ_SPARE,  1'b0, 2'd1, 32'hAAAA_5555, 1'b0, '0);
        add_row(REQ_SAMPLE, 1'b0, 2'd3, 32'h5555_AAAA, 1'b0, '0);
        add_row(REQ_SAMPLE, 1'b1, 2'd0, 32'h0000_0002, 1'b0, '0);
        add_row(REQ_SAMPLE, 1'b1, 2'd1, 32'h0000_0003, 1'b0, '0);
        add_row(REQ_LOST,   1'b1, 2'd1, 32'h0000_0004, 1'b0, '0);
        add_row(REQ_LOST,   1'b0, 2'd3, 32'h0000_0005, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            issue(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                issue(random_request(), 1'b0, '0);
            end
        end

        send_idle_pct = 31;
        stall_pct = 31;
        repeat (TAIL_ITEMS) begin
            issue(random_request(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        stall_pct = 0;

        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests with %0d grants and %0d evictions;", request_count,
                 grant_count, evict_count);
        $display("flap count ended at %0d, %0d errors seen.", flap_seen, error_count);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
